// ===== hdl/phd_pkg.sv =====
// shared types and constants of the ppp async hdlc deframer
`default_nettype none
package phd_pkg;

  // field widths
  localparam int MAX_UNIT_W = 13;
  localparam int LEN_W      = 13;
  localparam int PROTO_W    = 16;
  localparam int STATUS_W   = 2;

  // reset value of the max unit register
  localparam logic [MAX_UNIT_W-1:0] MAX_UNIT_RESET = 13'd1500;

  // framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] ADDR_BYTE = 8'hFF;
  localparam logic [7:0] CTRL_BYTE = 8'h03;

  // fcs-16, reflected
  localparam logic [15:0] FCS_POLY = 16'h8408;
  localparam logic [15:0] FCS_INIT = 16'hFFFF;
  localparam logic [15:0] FCS_GOOD = 16'hF0B8;

  // shortest frame that can be checked
  localparam int MIN_FRAME = 4;

  // token queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // one classified beat: a flag or an unescaped byte
  typedef struct packed {
    logic       is_flag;
    logic [7:0] value;
  } tok_t;

  // fcs-16 update over one byte
  function automatic logic [15:0] fcs16_byte(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/phd_if.sv =====
// channel interfaces of the deframer
`default_nettype none
interface phd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface phd_out_if import phd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                is_end;
  logic [7:0]          data_byte;
  logic [PROTO_W-1:0]  protocol;
  logic [STATUS_W-1:0] frame_status;
  logic [LEN_W-1:0]    payload_length;
  modport source (output valid, output is_end, output data_byte, output protocol,
                  output frame_status, output payload_length, input ready);
  modport sink (input valid, input is_end, input data_byte, input protocol,
                input frame_status, input payload_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/phd_front.sv =====
// front end: flag detection and escape removal on raw bytes
`default_nettype none
module phd_front import phd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  phd_in_if.sink     in_bus,
  input  logic       q_full,
  output logic       push,
  output tok_t       push_tok
);

  logic escape_r, escape_nxt;
  logic acc;

  assign in_bus.ready = !q_full;
  assign acc          = in_bus.valid && !q_full;

  // classify the beat
  always_comb begin
    escape_nxt = escape_r;
    push       = 1'b0;
    push_tok   = '{is_flag: 1'b0, value: in_bus.rx_byte};
    if (acc) begin
      priority if (in_bus.rx_byte == FLAG_BYTE) begin
        push             = 1'b1;
        push_tok.is_flag = 1'b1;
        escape_nxt       = 1'b0;
      end else if (escape_r) begin
        push           = 1'b1;
        push_tok.value = in_bus.rx_byte ^ ESC_XOR;
        escape_nxt     = 1'b0;
      end else if (in_bus.rx_byte == ESC_BYTE) begin
        escape_nxt = 1'b1;
      end else begin
        push = 1'b1;
      end
    end
  end

  // escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= 1'b0;
    end else begin
      escape_r <= escape_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/phd_queue.sv =====
// short token queue between front and back
`default_nettype none
module phd_queue import phd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output tok_t q_tok
);

  tok_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = count_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign q_valid = count_r != '0;
  assign q_tok   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/phd_back.sv =====
// back end: fcs check, header decode, payload delay and result register
`default_nettype none
module phd_back import phd_pkg::*; #(
  parameter int FRAME_HEADROOM = 16,
  parameter int MAX_UNIT_LIMIT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [MAX_UNIT_W-1:0] max_unit,
  input  logic                  q_valid,
  input  tok_t                  q_tok,
  output logic                  pop,
  phd_out_if.source             out_bus
);

  localparam int CNT_W = $clog2(MAX_UNIT_LIMIT + FRAME_HEADROOM + 2);

  typedef enum logic [6:0] {
    HP_FIRST    = 7'b0000001,
    HP_SAW_FF   = 7'b0000010,
    HP_PROTO    = 7'b0000100,
    HP_PROTO_LO = 7'b0001000,
    HP_DONE0    = 7'b0010000,
    HP_DONE1    = 7'b0100000,
    HP_DONE2    = 7'b1000000
  } hphase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GOOD     = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BAD_FCS  = 2'd2,
    ST_NO_PROTO = 2'd3
  } status_t;

  logic [CNT_W-1:0]   stored_r, stored_nxt;
  logic [15:0]        fcs_r, fcs_nxt;
  hphase_t            phase_r, phase_nxt;
  logic [PROTO_W-1:0] proto_r, proto_nxt;
  logic [LEN_W-1:0]   pcount_r, pcount_nxt;
  logic [7:0]         held0_r, held0_nxt, held1_r, held1_nxt;

  logic               ovalid_r;
  logic               oend_r, oend_nxt;
  logic [7:0]         odata_r, odata_nxt;
  logic [PROTO_W-1:0] oproto_r, oproto_nxt;
  status_t            ostat_r, ostat_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;

  logic               take, produce;
  logic [CNT_W-1:0]   mtu, cap;
  logic [7:0]         v;
  status_t            stat;

  assign take = q_valid && (!ovalid_r || out_bus.ready);
  assign pop  = take;
  assign v    = q_tok.value;

  // size cap of the stored frame
  always_comb begin
    if (32'(max_unit) > 32'(MAX_UNIT_LIMIT)) begin
      mtu = CNT_W'(MAX_UNIT_LIMIT);
    end else begin
      mtu = CNT_W'(max_unit);
    end
    cap = mtu + CNT_W'(FRAME_HEADROOM);
  end

  // end status, in priority order
  always_comb begin
    priority if (stored_r < CNT_W'(MIN_FRAME)) begin
      stat = ST_SHORT;
    end else if (fcs_r != FCS_GOOD) begin
      stat = ST_BAD_FCS;
    end else if (phase_r != HP_DONE2) begin
      stat = ST_NO_PROTO;
    end else begin
      stat = ST_GOOD;
    end
  end

  // frame processing of one token
  always_comb begin
    stored_nxt = stored_r;
    fcs_nxt    = fcs_r;
    phase_nxt  = phase_r;
    proto_nxt  = proto_r;
    pcount_nxt = pcount_r;
    held0_nxt  = held0_r;
    held1_nxt  = held1_r;
    produce    = 1'b0;
    oend_nxt   = 1'b0;
    odata_nxt  = 8'h00;
    oproto_nxt = '0;
    ostat_nxt  = ST_GOOD;
    olen_nxt   = '0;
    if (take) begin
      if (q_tok.is_flag) begin
        if (stored_r != '0) begin
          produce    = 1'b1;
          oend_nxt   = 1'b1;
          ostat_nxt  = stat;
          oproto_nxt = (stat == ST_GOOD) ? proto_r : '0;
          olen_nxt   = (stat == ST_GOOD) ? pcount_r : '0;
          stored_nxt = '0;
          fcs_nxt    = FCS_INIT;
          phase_nxt  = HP_FIRST;
          proto_nxt  = '0;
          pcount_nxt = '0;
        end
      end else if (!(stored_r > cap)) begin
        fcs_nxt = fcs16_byte(fcs_r, v);
        unique case (phase_r)
          HP_SAW_FF: begin
            if (v == CTRL_BYTE) begin
              phase_nxt = HP_PROTO;
            end else begin
              proto_nxt = PROTO_W'(ADDR_BYTE);
              phase_nxt = HP_DONE1;
            end
          end
          HP_PROTO: begin
            if (v[0]) begin
              proto_nxt = PROTO_W'(v);
              phase_nxt = HP_DONE0;
            end else begin
              proto_nxt = {v, 8'h00};
              phase_nxt = HP_PROTO_LO;
            end
          end
          HP_PROTO_LO: begin
            proto_nxt = proto_r | PROTO_W'(v);
            phase_nxt = HP_DONE0;
          end
          HP_DONE0: phase_nxt = HP_DONE1;
          HP_DONE1: phase_nxt = HP_DONE2;
          HP_DONE2: begin
            produce    = 1'b1;
            odata_nxt  = held1_r;
            oproto_nxt = proto_r;
            pcount_nxt = pcount_r + 1'b1;
          end
          // first byte, and any code that means nothing
          default: begin
            if (v == ADDR_BYTE) begin
              phase_nxt = HP_SAW_FF;
            end else if (v[0]) begin
              proto_nxt = PROTO_W'(v);
              phase_nxt = HP_DONE0;
            end else begin
              proto_nxt = {v, 8'h00};
              phase_nxt = HP_PROTO_LO;
            end
          end
        endcase
        held1_nxt  = held0_r;
        held0_nxt  = v;
        stored_nxt = stored_r + 1'b1;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
      fcs_r    <= FCS_INIT;
      phase_r  <= HP_FIRST;
      proto_r  <= '0;
      pcount_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      stored_r <= stored_nxt;
      fcs_r    <= fcs_nxt;
      phase_r  <= phase_nxt;
      proto_r  <= proto_nxt;
      pcount_r <= pcount_nxt;
      if (produce) begin
        ovalid_r <= 1'b1;
      end else if (out_bus.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // held bytes and result payload
  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    if (produce) begin
      oend_r   <= oend_nxt;
      odata_r  <= odata_nxt;
      oproto_r <= oproto_nxt;
      ostat_r  <= ostat_nxt;
      olen_r   <= olen_nxt;
    end
  end

  assign out_bus.valid          = ovalid_r;
  assign out_bus.is_end         = oend_r;
  assign out_bus.data_byte      = odata_r;
  assign out_bus.protocol       = oproto_r;
  assign out_bus.frame_status   = ostat_r;
  assign out_bus.payload_length = olen_r;

endmodule
`default_nettype wire

// ===== hdl/ppp_async_hdlc_deframer.sv =====
// path: a raw byte is registered in the token queue, then its result beat is registered;
// throughput: one raw byte per cycle unless the queue is full, set by the fcs and header
// update in the back end; a four-entry queue decouples byte intake from result drain
// reset: synchronous active-low rst_n clears escape, frame state, queue and result
// valid; max_unit returns to 1500; held bytes and result payload are not reset
`default_nettype none
module ppp_async_hdlc_deframer import phd_pkg::*; #(
  parameter int FRAME_HEADROOM = 16,
  parameter int MAX_UNIT_LIMIT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [MAX_UNIT_W-1:0] cfg_wdata,
  phd_in_if.sink                in_bus,
  phd_out_if.source             out_bus
);

  logic [MAX_UNIT_W-1:0] max_unit_r;
  logic                  q_full, push, pop, q_valid;
  tok_t                  push_tok, q_tok;

  // max unit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_unit_r <= MAX_UNIT_RESET;
    end else if (cfg_we) begin
      max_unit_r <= cfg_wdata;
    end
  end

  phd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  phd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  phd_back #(
    .FRAME_HEADROOM (FRAME_HEADROOM),
    .MAX_UNIT_LIMIT (MAX_UNIT_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .max_unit (max_unit_r),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .pop      (pop),
    .out_bus  (out_bus)
  );

`ifndef SYNTHESIS
  // a flag beat always lands in the queue
  a_flag_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.rx_byte == FLAG_BYTE) |=> q_valid)
    else $error("flag beat not queued");

  // input backpressure only when tokens are waiting
  a_stall_has_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> q_valid)
    else $error("input stalled with empty queue");

  // a new result needs a token consumed the cycle before
  a_result_from_token: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(q_valid))
    else $error("result without a queued token");
`endif

endmodule
`default_nettype wire

// ===== tb/phd_tb_pkg.sv =====
// frame predictor and result scoreboard for the ppp async hdlc deframer testbench
package phd_tb_pkg;
  import phd_pkg::*;

  // block parameters at their default values
  localparam int FRAME_HEADROOM = 16;
  localparam int MAX_UNIT_LIMIT = 4096;

  typedef enum logic [1:0] {
    FS_GOOD     = 2'd0,
    FS_SHORT    = 2'd1,
    FS_BAD_FCS  = 2'd2,
    FS_NO_PROTO = 2'd3
  } frame_status_e;

  // where the frame header stands
  typedef enum logic [2:0] {
    HP_FIRST       = 3'd0,
    HP_ADDR        = 3'd1,
    HP_PROTO_FIRST = 3'd2,
    HP_PROTO_LO    = 3'd3,
    HP_TAIL0       = 3'd4,
    HP_TAIL1       = 3'd5,
    HP_PAYLOAD     = 3'd6
  } hdr_phase_e;

  // one result beat
  typedef struct packed {
    logic        is_end;
    logic [7:0]  data;
    logic [15:0] proto;
    logic [1:0]  status;
    logic [12:0] len;
  } deframe_beat_t;

  typedef logic [7:0] byte_q_t[$];

  // fcs-16 advanced one bit at a time, lsb first
  function automatic logic [15:0] fcs16_next(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r = {1'b0, r[15:1]};
      if (fb) r = r ^ FCS_POLY;
    end
    return r;
  endfunction

  class deframe_scoreboard;
    logic [12:0]   max_unit;
    bit            escape_armed;
    int unsigned   stored_bytes;
    logic [15:0]   fcs_acc;
    logic [7:0]    prev_byte;
    logic [7:0]    prev2_byte;
    hdr_phase_e    hdr;
    logic [15:0]   proto_acc;
    logic [12:0]   payload_beats;
    deframe_beat_t expected_beats[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   payload_seen;
    int unsigned   status_seen[4];

    function new();
      max_unit = MAX_UNIT_RESET;
      prev_byte = 8'h00;
      prev2_byte = 8'h00;
      mismatches = 0;
      results_seen = 0;
      payload_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      escape_armed = 1'b0;
      stored_bytes = 0;
      fcs_acc = FCS_INIT;
      hdr = HP_FIRST;
      proto_acc = 16'h0000;
      payload_beats = '0;
    endfunction

    function void set_max_unit(logic [12:0] v);
      max_unit = v;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // odd first byte is the whole protocol, even one is the high byte
    function void take_first_proto(logic [7:0] v);
      if (v[0]) begin
        proto_acc = {8'h00, v};
        hdr = HP_TAIL0;
      end else begin
        proto_acc = {v, 8'h00};
        hdr = HP_PROTO_LO;
      end
    endfunction

    // advance the frame state by one accepted raw byte
    function void note_rx_byte(logic [7:0] raw);
      logic [7:0]    v;
      int unsigned   cap;
      frame_status_e st;
      deframe_beat_t beat;
      v = raw;

      // a flag closes the frame, even right after an escape
      if (v == FLAG_BYTE) begin
        if (stored_bytes != 0) begin
          if (stored_bytes < MIN_FRAME) st = FS_SHORT;
          else if (fcs_acc != FCS_GOOD) st = FS_BAD_FCS;
          else if (hdr != HP_PAYLOAD) st = FS_NO_PROTO;
          else st = FS_GOOD;
          beat.is_end = 1'b1;
          beat.data = 8'h00;
          beat.proto = (st == FS_GOOD) ? proto_acc : 16'h0000;
          beat.status = st;
          beat.len = (st == FS_GOOD) ? payload_beats : 13'd0;
          expected_beats = {expected_beats, beat};
        end
        clear_frame();
        return;
      end

      // unescape
      if (escape_armed) begin
        v = v ^ ESC_XOR;
        escape_armed = 1'b0;
      end else if (v == ESC_BYTE) begin
        escape_armed = 1'b1;
        return;
      end

      // bytes past the cap leave all frame state but the escape flag alone
      cap = (max_unit > MAX_UNIT_LIMIT) ? MAX_UNIT_LIMIT : max_unit;
      if (stored_bytes > cap + FRAME_HEADROOM) return;

      fcs_acc = fcs16_next(fcs_acc, v);
      case (hdr)
        HP_ADDR: begin
          if (v == CTRL_BYTE) hdr = HP_PROTO_FIRST;
          else begin
            proto_acc = {8'h00, ADDR_BYTE};
            hdr = HP_TAIL1;
          end
        end
        HP_PROTO_FIRST: take_first_proto(v);
        HP_PROTO_LO: begin
          proto_acc[7:0] = v;
          hdr = HP_TAIL0;
        end
        HP_TAIL0: hdr = HP_TAIL1;
        HP_TAIL1: hdr = HP_PAYLOAD;
        HP_PAYLOAD: begin
          // payload goes out two bytes late so the fcs pair never shows
          beat.is_end = 1'b0;
          beat.data = prev2_byte;
          beat.proto = proto_acc;
          beat.status = FS_GOOD;
          beat.len = 13'd0;
          expected_beats = {expected_beats, beat};
          payload_beats = payload_beats + 13'd1;
        end
        default: begin
          if (v == ADDR_BYTE) hdr = HP_ADDR;
          else take_first_proto(v);
        end
      endcase
      prev2_byte = prev_byte;
      prev_byte = v;
      stored_bytes++;
    endfunction

    function string beat_text(deframe_beat_t b);
      return $sformatf("end=%0b byte=%02h proto=%04h status=%0d len=%0d",
                       b.is_end, b.data, b.proto, b.status, b.len);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    // compare one accepted result beat with the oldest prediction
    function void check_beat(logic is_end, logic [7:0] data, logic [15:0] proto,
                             logic [1:0] status, logic [12:0] len);
      deframe_beat_t got;
      deframe_beat_t want;
      got = {is_end, data, proto, status, len};
      results_seen++;
      if (expected_beats.size() == 0) begin
        report($sformatf("beat with nothing expected: %s", beat_text(got)));
        return;
      end
      want = expected_beats[0];
      expected_beats.delete(0);
      if (got.is_end !== want.is_end || got.data !== want.data ||
          got.proto !== want.proto || got.status !== want.status ||
          got.len !== want.len) begin
        report($sformatf("expected %s, got %s", beat_text(want), beat_text(got)));
      end
      if (want.is_end) status_seen[want.status]++;
      else payload_seen++;
    endfunction
  endclass

endpackage

// ===== tb/tb_ppp_async_hdlc_deframer.sv =====
// testbench top: drives raw serial bytes into the deframer and checks every result beat
module tb_ppp_async_hdlc_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import phd_pkg::*;
  import phd_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_BYTES   = 300;
  localparam logic [7:0] ODD_BYTES [5] = '{8'h7E, 8'h7D, 8'hFF, 8'h03, 8'h5E};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [MAX_UNIT_W-1:0] cfg_wdata = '0;

  phd_in_if  in_bus ();
  phd_out_if out_bus ();

  deframe_scoreboard sb = new();

  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          hold_request = 0;
  int unsigned cycle_count = 0;
  int unsigned frames_sent = 0;
  int unsigned bytes_sent = 0;

  ppp_async_hdlc_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  always #5ns clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_ppp_async_hdlc_deframer NOT OK");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      sb.check_beat(out_bus.is_end, out_bus.data_byte, out_bus.protocol,
                    out_bus.frame_status, out_bus.payload_length);
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // one raw byte beat, with random gaps in front
  task automatic send_byte(input logic [7:0] b);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_bus.valid <= 1'b1;
    in_bus.rx_byte <= b;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    sb.note_rx_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_q_t raw);
    foreach (raw[i]) send_byte(raw[i]);
    frames_sent++;
    bytes_sent += raw.size();
  endtask

  // stop sending until every predicted beat is out and the block is quiet
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_unit(input logic [MAX_UNIT_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_max_unit(v);
  endtask

  // optionally append fcs and flip one bit, escape and close with a flag
  function automatic byte_q_t encode_frame(byte_q_t body, bit with_fcs, bit spoil,
                                           int esc_pct);
    byte_q_t     plain;
    byte_q_t     raw;
    logic [15:0] acc;
    int          idx;
    plain = body;
    acc = FCS_INIT;
    if (with_fcs) begin
      foreach (body[i]) acc = fcs16_next(acc, body[i]);
      acc = ~acc;
      plain = {plain, acc[7:0]};
      plain = {plain, acc[15:8]};
    end
    if (spoil && plain.size() > 0) begin
      idx = $urandom_range(0, plain.size() - 1);
      plain[idx] = plain[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    // 0x5e must not be escaped by choice, it would turn into a flag
    foreach (plain[i]) begin
      if (plain[i] == FLAG_BYTE || plain[i] == ESC_BYTE ||
          (plain[i] != (FLAG_BYTE ^ ESC_XOR) && $urandom_range(0, 99) < esc_pct)) begin
        raw = {raw, ESC_BYTE};
        raw = {raw, plain[i] ^ ESC_XOR};
      end else begin
        raw = {raw, plain[i]};
      end
    end
    raw = {raw, FLAG_BYTE};
    return raw;
  endfunction

  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 9) == 0) return ODD_BYTES[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed frames with random content, some broken ones and line noise
  function automatic byte_q_t random_frame(int unsigned store_cap);
    byte_q_t     body;
    byte_q_t     raw;
    int          kind;
    int          n;
    int          r;
    logic [7:0]  p;
    kind = $urandom_range(0, 99);

    // line noise, rich in flags and escapes
    if (kind >= 92) begin
      n = $urandom_range(1, 30);
      repeat (n) begin
        r = $urandom_range(0, 99);
        raw = {raw, (r < 15 ? ESC_BYTE : r < 25 ? FLAG_BYTE : 8'($urandom_range(0, 255)))};
      end
      raw = {raw, FLAG_BYTE};
      return raw;
    end

    // header
    if ($urandom_range(0, 9) < 7) begin
      body = {body, ADDR_BYTE};
      body = {body, CTRL_BYTE};
    end
    p = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) body = {body, ADDR_BYTE};
    else begin
      body = {body, p};
      if (!p[0]) body = {body, 8'($urandom_range(0, 255))};
    end

    // payload, now and then past the stored cap
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(0, 20);
    else if (r < 95 || store_cap > 200) n = $urandom_range(21, 90);
    else n = store_cap + $urandom_range(0, 6);
    repeat (n) body = {body, payload_byte()};

    if (kind < 72) raw = encode_frame(body, 1'b1, 1'b0, 5);
    else if (kind < 80) raw = encode_frame(body, 1'b1, 1'b1, 5);
    else if (kind < 86) begin
      // truncated frame: too short, or header left incomplete
      n = $urandom_range(0, 4);
      while (body.size() > n) void'(body.pop_back());
      raw = encode_frame(body, 1'($urandom_range(0, 1)), 1'b0, 5);
    end else begin
      // escape right before the closing flag
      raw = encode_frame(body, 1'b1, 1'b0, 5);
      raw[raw.size() - 1] = ESC_BYTE;
      raw = {raw, FLAG_BYTE};
    end
    if ($urandom_range(0, 3) == 0) raw.push_front(FLAG_BYTE);
    return raw;
  endfunction

  task automatic run_random(input int unsigned target, input int unsigned store_cap);
    int unsigned sent;
    byte_q_t     raw;
    sent = 0;
    while (sent < target) begin
      raw = random_frame(store_cap);
      sent += raw.size();
      send_frame(raw);
      if ($urandom_range(0, 39) == 0) settle();
    end
  endtask

  // stimulus
  initial begin
    byte_q_t body;
    byte_q_t raw;
    in_bus.valid = 1'b0;
    in_bus.rx_byte = 8'h00;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at the reset max unit
    in_idle_pct = 23;
    out_idle_pct = 88;
    send_byte(FLAG_BYTE);
    send_byte(FLAG_BYTE);
    body = '{ADDR_BYTE, CTRL_BYTE, 8'hC0, 8'h21, 8'h01, 8'h02};
    send_frame(encode_frame(body, 1'b1, 1'b0, 0));
    // escape then flag on an empty frame, then on a frame with data
    send_byte(ESC_BYTE);
    send_byte(FLAG_BYTE);
    raw = '{8'h21, ESC_BYTE, FLAG_BYTE};
    send_frame(raw);
    raw = '{8'h21, FLAG_BYTE};
    send_frame(raw);
    // escaped flag and escaped escape in the payload
    body = '{8'h21, ESC_BYTE, FLAG_BYTE, 8'h00, 8'hFF, 8'h80};
    send_frame(encode_frame(body, 1'b1, 1'b0, 0));
    raw = '{8'h21, 8'h00, 8'h00, 8'h00, 8'h00, FLAG_BYTE};
    send_frame(raw);
    // header that never completes, address without control, two-byte protocol
    body = '{ADDR_BYTE, CTRL_BYTE, 8'h00};
    send_frame(encode_frame(body, 1'b1, 1'b0, 0));
    body = '{ADDR_BYTE, 8'h21, 8'hAA, 8'h55};
    send_frame(encode_frame(body, 1'b1, 1'b0, 0));
    body = '{8'h00, 8'h57, 8'h45};
    send_frame(encode_frame(body, 1'b1, 1'b0, 0));

    // max unit below its range: a frame that just fits, then one that overflows
    write_max_unit(13'd3);
    body = '{8'h21};
    repeat (17) body = {body, payload_byte()};
    send_frame(encode_frame(body, 1'b1, 1'b0, 0));
    body = '{8'h21};
    repeat (22) body = {body, payload_byte()};
    send_frame(encode_frame(body, 1'b1, 1'b0, 0));

    // sender mostly busy, receiver mostly stalled
    write_max_unit(13'd64);
    in_idle_pct = 23;
    out_idle_pct = 88;
    run_random(PHASE_BYTES, 64 + FRAME_HEADROOM + 1);

    // sender mostly idle, receiver mostly ready
    write_max_unit(13'd4096);
    in_idle_pct = 88;
    out_idle_pct = 23;
    run_random(PHASE_BYTES, MAX_UNIT_LIMIT + FRAME_HEADROOM + 1);

    // no idling; max unit above the limit
    write_max_unit(13'd8191);
    in_idle_pct = 0;
    out_idle_pct = 0;
    // long receiver hold-off while payload keeps coming
    hold_request = 300;
    body = '{ADDR_BYTE, CTRL_BYTE, 8'h21};
    repeat (60) body = {body, payload_byte()};
    send_frame(encode_frame(body, 1'b1, 1'b0, 3));
    run_random(PHASE_BYTES, MAX_UNIT_LIMIT + FRAME_HEADROOM + 1);

    settle();
    $display("sent %0d raw bytes in %0d frames over max unit 1500, 3, 64, 4096 and 8191",
             bytes_sent, frames_sent);
    $display("checked %0d payload beats; frame ends good/short/bad fcs/no protocol: %0d/%0d/%0d/%0d",
             sb.payload_seen, sb.status_seen[FS_GOOD], sb.status_seen[FS_SHORT],
             sb.status_seen[FS_BAD_FCS], sb.status_seen[FS_NO_PROTO]);
    if (sb.mismatches == 0) begin
      $display("tb_ppp_async_hdlc_deframer OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_ppp_async_hdlc_deframer NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/phd_pkg.sv
hdl/phd_if.sv
hdl/phd_front.sv
hdl/phd_queue.sv
hdl/phd_back.sv
hdl/ppp_async_hdlc_deframer.sv
tb/phd_tb_pkg.sv
tb/tb_ppp_async_hdlc_deframer.sv
